### hw/rtl/hough_line_vote_peaks_assert.svh
// assertion macros for the hough line vote block
// no dependencies; included by the top level, which carries the assertions
`ifndef HOUGH_LINE_VOTE_PEAKS_ASSERT_SVH
`define HOUGH_LINE_VOTE_PEAKS_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define HLVP_ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hlvp assertion failed");

// next-cycle implication, disabled while reset is held
`define HLVP_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hlvp assertion failed");

`endif

### hw/rtl/hlvp_pkg.sv
// shared types, codes and trig table functions of the hough line vote block
// no dependencies
package hlvp_pkg;

  // request codes
  localparam logic REQ_VOTE   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_RHO_ROWS  = 3'd0;
  localparam logic [2:0] REG_DIAG_Q8   = 3'd1;
  localparam logic [2:0] REG_SCALE_Q16 = 3'd2;
  localparam logic [2:0] REG_THRESHOLD = 3'd3;
  localparam logic [2:0] REG_TOP_K     = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // angle constants in Q30 radians
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef struct packed {
    logic        req_type;
    logic [10:0] point_x;
    logic [10:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [11:0] rho_index;
    logic [7:0]  theta_index;
    logic [15:0] vote_count;
    logic        peak_valid;
    logic        last_peak;
  } out_item_t;

  // controls of the sorted peak list
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } rank_ctrl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_PREP,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } state_e;

  // sine of an angle in [0, pi/2], Q30 in and out, taylor series to x^13
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] f;
    logic [63:0] p;
    logic [63:0] d;
    x2 = (x * x) >> 30;
    f  = ONE_Q30;
    for (int i = 0; i < 6; i++) begin
      p = (x2 * f) >> 30;
      case (i)
        0: d = p / 156;
        1: d = p / 110;
        2: d = p / 72;
        3: d = p / 42;
        4: d = p / 20;
        default: d = p / 6;
      endcase
      f = (d >= ONE_Q30) ? 64'd0 : ONE_Q30 - d;
    end
    return (x * f) >> 30;
  endfunction

  // round Q30 to Q15, half up, capped below one
  function automatic logic [15:0] to_q15(input logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 16'd32767 : r[15:0];
  endfunction

endpackage

### hw/rtl/hlvp_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module hlvp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/hlvp_rank.sv
// sorted peak list: a row of insertion cells ordered by votes, read from the head
// depends on hlvp_pkg
module hlvp_rank #(
  parameter int DEPTH = 64,
  parameter int VW    = 16,
  parameter int RW    = 13,
  parameter int TW    = 8,
  parameter int LW    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hlvp_pkg::rank_ctrl_t ctrl_i,
  input  logic [LW-1:0]       limit_i,
  input  logic [RW-1:0]       new_rho_i,
  input  logic [TW-1:0]       new_theta_i,
  input  logic [VW-1:0]       new_votes_i,
  output logic [LW-1:0]       count_o,
  output logic [RW-1:0]       head_rho_o,
  output logic [TW-1:0]       head_theta_o,
  output logic [VW-1:0]       head_votes_o
);

  typedef struct packed {
    logic [RW-1:0] rho;
    logic [TW-1:0] theta;
    logic [VW-1:0] votes;
  } entry_t;

  entry_t            cell_q [DEPTH];
  entry_t            new_entry;
  logic [DEPTH-1:0]  ge;
  logic [DEPTH-1:0]  ins_here;
  logic [DEPTH-1:0]  below;
  logic              ins_ok;
  logic              prev_ge;
  logic [LW-1:0]     count_q;

  assign new_entry = '{rho: new_rho_i, theta: new_theta_i, votes: new_votes_i};

  // each cell compares against the new item; ties stay ahead of it
  always_comb begin
    prev_ge = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      ge[i]       = (LW'(i) < count_q) && (cell_q[i].votes >= new_votes_i);
      below[i]    = LW'(i) < limit_i;
      ins_here[i] = !ge[i] && prev_ge;
      prev_ge     = ge[i];
    end
  end

  // insertion point lies within the kept part of the list
  assign ins_ok = |(~ge & below);

  // cells: keep, take the new item, move down on insert or move up on read
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t down_src;
    entry_t up_src;
    if (g == 0) begin : g_first
      assign down_src = new_entry;
    end else begin : g_rest
      assign down_src = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign up_src = cell_q[g];
    end else begin : g_mid
      assign up_src = cell_q[g+1];
    end
    always_ff @(posedge clk_i) begin
      if (ctrl_i.insert && ins_ok && !ge[g]) begin
        cell_q[g] <= ins_here[g] ? new_entry : down_src;
      end else if (ctrl_i.shift) begin
        cell_q[g] <= up_src;
      end
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.insert && ins_ok && (count_q < limit_i)) begin
      count_q <= count_q + LW'(1);
    end else if (ctrl_i.shift && (count_q != '0)) begin
      count_q <= count_q - LW'(1);
    end
  end

  assign count_o      = count_q;
  assign head_rho_o   = cell_q[0].rho;
  assign head_theta_o = cell_q[0].theta;
  assign head_votes_o = cell_q[0].votes;

endmodule

### hw/rtl/hough_line_vote_peaks.sv
// hough line accumulator with peak reporting, top level
// depends on hlvp_pkg, hlvp_ram, hlvp_rank and hough_line_vote_peaks_assert.svh
//
// usage:
// - an item is taken when start_i is high and busy_o is low; item_i.req_type
//   selects a vote (edge point) or a finish (report peaks and clear)
// - a vote walks the theta bins one per cycle through a six stage pipeline
//   (two products, sum, scale product, round and range check, address, then a
//   read-modify-write of the vote memory); busy_o stays high through the walk
//   and until the pipeline drains, sooner when the last bins fall out of range
// - a finish sweeps the vote memory one bin per cycle over max(rho rows, highest
//   voted row + 1) rows, zeroing behind the read and feeding a sorted list of
//   insertion cells; busy_o stays high through the sweep and while the results
//   go out, the last result showing in the first idle cycle
// - results come out on result_o with result_valid_o high for one cycle each,
//   best first, the last marked by last_peak; a finish with no peak gives one
//   result with peak_valid low
// - the receiver cannot stall; results go out at one per cycle
// - after reset the vote memory is cleared, one entry per cycle, over all
//   THETA_COUNT * MAX_RHO_ROWS entries with busy_o high; cfg writes through
//   cfg_we_i, cfg_idx_i and cfg_data_i belong between items, with busy_o low
`include "hough_line_vote_peaks_assert.svh"

module hough_line_vote_peaks #(
  parameter int THETA_COUNT  = 180,
  parameter int MAX_RHO_ROWS = 4096,
  parameter int MAX_TOP      = 64,
  parameter int VOTE_WIDTH   = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  hlvp_pkg::in_item_t             item_i,
  output logic                           busy_o,
  output logic                           result_valid_o,
  output hlvp_pkg::out_item_t            result_o,
  input  logic                           cfg_we_i,
  input  logic [hlvp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hlvp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH = THETA_COUNT * MAX_RHO_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RHO_ROWS + 1);
  localparam int TW    = $clog2(THETA_COUNT);
  localparam int LW    = $clog2(MAX_TOP + 1);
  localparam int VW    = VOTE_WIDTH;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [TW-1:0] LAST_T    = TW'(THETA_COUNT - 1);

  // configuration registers
  logic [12:0] rho_rows_q;
  logic [19:0] diag_q;
  logic [23:0] scale_q;
  logic [15:0] thr_q;
  logic [6:0]  topk_q;

  hlvp_pkg::state_e state_q, state_d;

  logic          accept;
  logic          vote_issue;
  logic          scan_issue;
  logic          emit;
  hlvp_pkg::rank_ctrl_t rank_ctrl;

  logic [RW-1:0] nb_w;
  logic [LW-1:0] lim_w;
  logic [LW-1:0] limit_q;

  // trig tables
  logic signed [15:0] cos_tab [THETA_COUNT];
  logic [15:0]        sin_tab [THETA_COUNT];

  // vote pipeline
  logic [10:0]        x_q, y_q;
  logic [TW-1:0]      t_q;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [TW-1:0]      t1_q, t2_q, t3_q, t4_q;
  logic signed [27:0] px_d, px1_q;
  logic [26:0]        py_d, py1_q;
  logic signed [29:0] s_d, s2_q;
  logic [52:0]        m_d, m3_q;
  logic [53:0]        rnd;
  logic [22:0]        bin_full;
  logic               in_range;
  logic [RW-1:0]      bin4_q;
  logic [RW-1:0]      bin4_inc;
  logic [AW-1:0]      addr5_q, addr6_q;
  logic [RW-1:0]      hw_q;
  logic               pipe_empty;

  // scan
  logic [AW-1:0]      clr_q;
  logic [AW-1:0]      sa_q, sa1_q;
  logic [RW-1:0]      sr_q, sr1_q;
  logic [TW-1:0]      st_q, st1_q;
  logic               sv_q, cons1_q;
  logic [AW-1:0]      scan_last_q;
  logic [RW-1:0]      rows_w;
  logic [AW:0]        rows_prod;

  // memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VW-1:0]      mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VW-1:0]      mem_rdata;

  // rank list
  logic [LW-1:0]      rank_count;
  logic [RW-1:0]      head_rho;
  logic [TW-1:0]      head_theta;
  logic [VW-1:0]      head_votes;

  // output register
  logic                result_valid_q;
  hlvp_pkg::out_item_t result_q, result_d;

  // cosine and sine tables worked out at elaboration
  for (genvar g = 0; g < THETA_COUNT; g++) begin : g_trig
    localparam logic [63:0] ANG = (64'(g) * hlvp_pkg::PI_Q30 * 64'd2 + 64'(THETA_COUNT))
                                / (64'd2 * 64'(THETA_COUNT));
    localparam bit UPPER = ANG > hlvp_pkg::HALF_PI_Q30;
    localparam logic [63:0] FOLD = !UPPER ? ANG :
      ((hlvp_pkg::PI_Q30 - ANG > hlvp_pkg::HALF_PI_Q30) ? hlvp_pkg::HALF_PI_Q30 :
       hlvp_pkg::PI_Q30 - ANG);
    localparam logic [15:0] SIN_V = hlvp_pkg::to_q15(hlvp_pkg::sin_q30(FOLD));
    localparam logic [15:0] COS_V =
      hlvp_pkg::to_q15(hlvp_pkg::sin_q30(hlvp_pkg::HALF_PI_Q30 - FOLD));
    localparam logic signed [15:0] COS_S = UPPER ? -$signed(COS_V) : $signed(COS_V);
    assign sin_tab[g] = SIN_V;
    assign cos_tab[g] = COS_S;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_rows_q <= 13'd1600;
      diag_q     <= 20'd204800;
      scale_q    <= 24'd65495;
      thr_q      <= 16'd120;
      topk_q     <= 7'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hlvp_pkg::REG_RHO_ROWS:  rho_rows_q <= cfg_data_i[12:0];
        hlvp_pkg::REG_DIAG_Q8:   diag_q     <= cfg_data_i[19:0];
        hlvp_pkg::REG_SCALE_Q16: scale_q    <= cfg_data_i;
        hlvp_pkg::REG_THRESHOLD: thr_q      <= cfg_data_i[15:0];
        hlvp_pkg::REG_TOP_K:     topk_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective rho row count and peak limit
  always_comb begin
    if (rho_rows_q == '0) begin
      nb_w = RW'(1);
    end else if (32'(rho_rows_q) > 32'(MAX_RHO_ROWS)) begin
      nb_w = RW'(MAX_RHO_ROWS);
    end else begin
      nb_w = RW'(rho_rows_q);
    end
    if (topk_q == '0) begin
      lim_w = LW'(1);
    end else if (32'(topk_q) > 32'(MAX_TOP)) begin
      lim_w = LW'(MAX_TOP);
    end else begin
      lim_w = LW'(topk_q);
    end
  end

  assign accept     = start_i && (state_q == hlvp_pkg::ST_IDLE);
  assign pipe_empty = !(v1_q || v2_q || v3_q || v4_q || v5_q || v6_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hlvp_pkg::ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = hlvp_pkg::ST_IDLE;
      end
      hlvp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (item_i.req_type == hlvp_pkg::REQ_FINISH) ? hlvp_pkg::ST_PREP
                                                               : hlvp_pkg::ST_VOTE;
        end
      end
      hlvp_pkg::ST_VOTE: begin
        if (t_q == LAST_T) state_d = hlvp_pkg::ST_DRAIN;
      end
      hlvp_pkg::ST_DRAIN: begin
        if (pipe_empty) state_d = hlvp_pkg::ST_IDLE;
      end
      hlvp_pkg::ST_PREP: state_d = hlvp_pkg::ST_SCAN;
      hlvp_pkg::ST_SCAN: begin
        if (sa_q == scan_last_q) state_d = hlvp_pkg::ST_TAIL;
      end
      hlvp_pkg::ST_TAIL: state_d = hlvp_pkg::ST_EMIT;
      hlvp_pkg::ST_EMIT: begin
        if (rank_count <= LW'(1)) state_d = hlvp_pkg::ST_IDLE;
      end
      default: state_d = hlvp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    vote_issue       = 1'b0;
    scan_issue       = 1'b0;
    emit             = 1'b0;
    rank_ctrl.clear  = 1'b0;
    rank_ctrl.shift  = 1'b0;
    rank_ctrl.insert = sv_q && cons1_q && (32'(mem_rdata) >= 32'(thr_q));
    case (state_q)
      hlvp_pkg::ST_VOTE: vote_issue = 1'b1;
      hlvp_pkg::ST_PREP: rank_ctrl.clear = 1'b1;
      hlvp_pkg::ST_SCAN: scan_issue = 1'b1;
      hlvp_pkg::ST_EMIT: begin
        emit            = 1'b1;
        rank_ctrl.shift = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlvp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == hlvp_pkg::ST_CLEAR) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // point capture and theta counter
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= item_i.point_x;
      y_q <= item_i.point_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= '0;
    end else if (vote_issue) begin
      t_q <= (t_q == LAST_T) ? '0 : t_q + TW'(1);
    end
  end

  // vote arithmetic, one stage per register
  assign px_d     = $signed({1'b0, x_q}) * cos_tab[t_q];
  assign py_d     = y_q * sin_tab[t_q];
  assign s_d      = $signed(30'(px1_q)) + $signed(30'(py1_q))
                  + $signed({3'b000, diag_q, 7'b0000000});
  assign m_d      = s2_q[28:0] * scale_q;
  assign rnd      = 54'(m3_q) + (54'd1 << 30);
  assign bin_full = rnd[53:31];
  assign in_range = 32'(bin_full) < 32'(nb_w);
  assign bin4_inc = bin4_q + RW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= vote_issue;
      v2_q <= v1_q;
      v3_q <= v2_q && !s2_q[29];
      v4_q <= v3_q && in_range;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= t_q;
    px1_q   <= px_d;
    py1_q   <= py_d;
    t2_q    <= t1_q;
    s2_q    <= s_d;
    t3_q    <= t2_q;
    m3_q    <= m_d;
    t4_q    <= t3_q;
    bin4_q  <= RW'(bin_full);
    addr5_q <= AW'(32'(bin4_q) * THETA_COUNT + 32'(t4_q));
    addr6_q <= addr5_q;
  end

  // one past the highest voted row since the last sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
    end else if (state_q == hlvp_pkg::ST_PREP) begin
      hw_q <= '0;
    end else if (v4_q && (bin4_inc > hw_q)) begin
      hw_q <= bin4_inc;
    end
  end

  // sweep bounds
  assign rows_w    = (nb_w > hw_q) ? nb_w : hw_q;
  assign rows_prod = (AW + 1)'(32'(rows_w) * THETA_COUNT);

  always_ff @(posedge clk_i) begin
    if (state_q == hlvp_pkg::ST_PREP) begin
      scan_last_q <= AW'(rows_prod - (AW + 1)'(1));
      limit_q     <= lim_w;
    end
  end

  // sweep counters, rho-major
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
      sr_q <= '0;
      st_q <= '0;
      sv_q <= 1'b0;
    end else begin
      sv_q <= scan_issue;
      if (state_q == hlvp_pkg::ST_PREP) begin
        sa_q <= '0;
        sr_q <= '0;
        st_q <= '0;
      end else if (scan_issue) begin
        sa_q <= sa_q + AW'(1);
        if (st_q == LAST_T) begin
          st_q <= '0;
          sr_q <= sr_q + RW'(1);
        end else begin
          st_q <= st_q + TW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sa1_q   <= sa_q;
    sr1_q   <= sr_q;
    st1_q   <= st_q;
    cons1_q <= sr_q < nb_w;
  end

  // memory port select
  always_comb begin
    mem_raddr = scan_issue ? sa_q : addr5_q;
    mem_we    = 1'b0;
    mem_waddr = addr6_q;
    mem_wdata = '0;
    if (state_q == hlvp_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (sv_q) begin
      mem_we    = 1'b1;
      mem_waddr = sa1_q;
    end else if (v6_q) begin
      mem_we    = 1'b1;
      mem_wdata = (mem_rdata == '1) ? mem_rdata : mem_rdata + VW'(1);
    end
  end

  hlvp_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_votes (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hlvp_rank #(
    .DEPTH (MAX_TOP),
    .VW    (VW),
    .RW    (RW),
    .TW    (TW),
    .LW    (LW)
  ) u_rank (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (rank_ctrl),
    .limit_i      (limit_q),
    .new_rho_i    (sr1_q),
    .new_theta_i  (st1_q),
    .new_votes_i  (mem_rdata),
    .count_o      (rank_count),
    .head_rho_o   (head_rho),
    .head_theta_o (head_theta),
    .head_votes_o (head_votes)
  );

  // result formatting from the list head
  always_comb begin
    result_d = '0;
    result_d.last_peak = rank_count <= LW'(1);
    if (rank_count != '0) begin
      result_d.rho_index   = 12'(head_rho);
      result_d.theta_index = 8'(head_theta);
      result_d.vote_count  = (32'(head_votes) > 32'(16'hFFFF)) ? 16'hFFFF
                                                               : 16'(head_votes);
      result_d.peak_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign busy_o         = state_q != hlvp_pkg::ST_IDLE;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // checks
  `HLVP_ASSERT_IMPL(a_last_leaves_idle, clk_i, rst_ni,
    result_valid_o && result_o.last_peak, state_q == hlvp_pkg::ST_IDLE)
  `HLVP_ASSERT_IMPL(a_count_in_limit, clk_i, rst_ni,
    state_q == hlvp_pkg::ST_EMIT, rank_count <= limit_q)
  `HLVP_ASSERT_IMPL(a_vote_write_in_vote, clk_i, rst_ni,
    v6_q, state_q == hlvp_pkg::ST_VOTE || state_q == hlvp_pkg::ST_DRAIN)
  `HLVP_ASSERT_NEXT(a_emit_gives_result, clk_i, rst_ni,
    state_q == hlvp_pkg::ST_EMIT, result_valid_o)

endmodule
